### rtl/core/tps_pkg.sv
// shared types and constants for the triangle pixel shader
// no dependencies; used by every module of the block
`default_nettype none

package tps_pkg;

    localparam int COORD_W    = 10;
    localparam int DELTA_W    = COORD_W + 1;
    localparam int PROD_W     = 2 * DELTA_W;
    localparam int EDGE_W     = PROD_W + 1;
    localparam int CHAN_W     = 4;
    localparam int COLOR_W    = 3 * CHAN_W;
    localparam int ADDR_W     = 20;
    localparam int ADDR_CALC_W = 21;
    localparam int RAMP_PROD_W = 15;
    localparam int RAMP_W     = RAMP_PROD_W - 8;
    localparam int CFG_DATA_W = COORD_W;

    localparam int SCREEN_WIDTH = 200;
    localparam int RAMP_GAIN    = 26;
    localparam int CHAN_MAX     = 15;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [2:0] {
        REG_FILL_MODE = 3'd0,
        REG_VERTEX_AX = 3'd1,
        REG_VERTEX_AY = 3'd2,
        REG_VERTEX_BX = 3'd3,
        REG_VERTEX_BY = 3'd4,
        REG_VERTEX_CX = 3'd5,
        REG_VERTEX_CY = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic               fill_mode;
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
    } shader_cfg_t;

    // pixel after the front: offsets to each vertex plus finished color and address
    typedef struct packed {
        logic                      fill;
        logic signed [DELTA_W-1:0] dx_a;
        logic signed [DELTA_W-1:0] dy_a;
        logic signed [DELTA_W-1:0] dx_b;
        logic signed [DELTA_W-1:0] dy_b;
        logic signed [DELTA_W-1:0] dx_c;
        logic signed [DELTA_W-1:0] dy_c;
        logic [COLOR_W-1:0]        color;
        logic [ADDR_W-1:0]         addr;
    } queue_item_t;

    typedef struct packed {
        logic                     fill;
        logic signed [PROD_W-1:0] pa0;
        logic signed [PROD_W-1:0] pb0;
        logic signed [PROD_W-1:0] pa1;
        logic signed [PROD_W-1:0] pb1;
        logic signed [PROD_W-1:0] pa2;
        logic signed [PROD_W-1:0] pb2;
        logic [COLOR_W-1:0]       color;
        logic [ADDR_W-1:0]        addr;
    } product_item_t;

    function automatic logic [CHAN_W-1:0] clamp_high(input logic [RAMP_W-1:0] v);
        logic [CHAN_W-1:0] res;
        if (v > RAMP_W'(CHAN_MAX)) begin
            res = CHAN_W'(CHAN_MAX);
        end else begin
            res = v[CHAN_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/core/triangle_pixel_shader.sv
// top level of the triangle pixel shader: config registers, front, queue, back
// depends on tps_pkg, tps_front, tps_queue, tps_back
`default_nettype none

// channel   direction  handshake               payload
// -------   ---------  ----------------------  ---------------------------------------
// cfg       in         cfg_valid / cfg_ready   cfg_index (3b), cfg_data (10b)
// pixel     in         in_valid / in_ready     pixel_x (10b), pixel_y (10b)
// result    out        out_valid / out_ready   inside_res, pixel_color, frame_address
//
// one pixel transfer per cycle sustained while out_ready stays high; a pixel passes
// through the front register, queue slot, edge product register and output register
// the queue of QUEUE_DEPTH entries lets the front keep taking pixels while the
// output is stalled; a stall at out_ready ripples back to in_ready once it is full
// reset (rst_n low) empties every stage and loads the vertex registers with their
// defaults; cfg_ready is always high, writes to an unknown index are dropped

module triangle_pixel_shader #(
    parameter int QUEUE_DEPTH = tps_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // config write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [2:0]                        cfg_index,
    input  wire logic [tps_pkg::CFG_DATA_W-1:0]    cfg_data,
    // pixel channel
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [tps_pkg::COORD_W-1:0]       pixel_x,
    input  wire logic [tps_pkg::COORD_W-1:0]       pixel_y,
    // result channel
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   inside_res,
    output logic [tps_pkg::COLOR_W-1:0]            pixel_color,
    output logic [tps_pkg::ADDR_W-1:0]             frame_address
);

    tps_pkg::shader_cfg_t cfg_reg;
    tps_pkg::shader_cfg_t cfg_next;

    logic                 push_valid;
    logic                 push_ready;
    tps_pkg::queue_item_t push_item;
    logic                 pop_valid;
    logic                 pop_ready;
    tps_pkg::queue_item_t pop_item;

    assign cfg_ready = 1'b1;

    // register file update, only the addressed register changes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (tps_pkg::reg_index_t'(cfg_index))
                tps_pkg::REG_FILL_MODE: cfg_next.fill_mode = cfg_data[0];
                tps_pkg::REG_VERTEX_AX: cfg_next.ax = cfg_data;
                tps_pkg::REG_VERTEX_AY: cfg_next.ay = cfg_data;
                tps_pkg::REG_VERTEX_BX: cfg_next.bx = cfg_data;
                tps_pkg::REG_VERTEX_BY: cfg_next.by = cfg_data;
                tps_pkg::REG_VERTEX_CX: cfg_next.cx = cfg_data;
                tps_pkg::REG_VERTEX_CY: cfg_next.cy = cfg_data;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.fill_mode <= 1'b0;
            cfg_reg.ax        <= tps_pkg::COORD_W'(50);
            cfg_reg.ay        <= tps_pkg::COORD_W'(20);
            cfg_reg.bx        <= tps_pkg::COORD_W'(150);
            cfg_reg.by        <= tps_pkg::COORD_W'(100);
            cfg_reg.cx        <= tps_pkg::COORD_W'(20);
            cfg_reg.cy        <= tps_pkg::COORD_W'(130);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front: offsets to the vertices, color ramps and frame address
    tps_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // decoupling queue so the front and back stall independently
    tps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // back: edge function products, sign test, result register
    tps_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .inside_res    (inside_res),
        .pixel_color   (pixel_color),
        .frame_address (frame_address)
    );

endmodule

`default_nettype wire

### rtl/core/tps_front.sv
// front stage: takes pixel transfers, computes vertex offsets, color and address
// depends on tps_pkg
`default_nettype none

module tps_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tps_pkg::shader_cfg_t          cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [tps_pkg::COORD_W-1:0]   pixel_x,
    input  wire logic [tps_pkg::COORD_W-1:0]   pixel_y,
    output logic                               push_valid,
    input  wire logic                          push_ready,
    output tps_pkg::queue_item_t               push_item
);

    logic                    front_valid_reg;
    logic                    front_valid_next;
    tps_pkg::queue_item_t    item_reg;
    tps_pkg::queue_item_t    item_next;
    logic                    load;

    logic [tps_pkg::RAMP_PROD_W-1:0] r_prod;
    logic [tps_pkg::RAMP_PROD_W-1:0] g_prod;
    logic [tps_pkg::RAMP_W-1:0]      r_raw;
    logic [tps_pkg::RAMP_W-1:0]      g_raw;
    logic [tps_pkg::RAMP_W-1:0]      half_sum;
    logic [tps_pkg::RAMP_W:0]        rg_sum;
    logic [tps_pkg::CHAN_W-1:0]      b_chan;
    logic [tps_pkg::ADDR_CALC_W-1:0] addr_full;

    function automatic logic signed [tps_pkg::DELTA_W-1:0] delta(
        input logic [tps_pkg::COORD_W-1:0] p,
        input logic [tps_pkg::COORD_W-1:0] v
    );
        return $signed({1'b0, p}) - $signed({1'b0, v});
    endfunction

    assign in_ready   = !front_valid_reg || push_ready;
    assign load       = in_valid && in_ready;
    assign push_valid = front_valid_reg;
    assign push_item  = item_reg;

    always_comb
    begin
        r_prod   = tps_pkg::RAMP_PROD_W'(pixel_x) * tps_pkg::RAMP_PROD_W'(tps_pkg::RAMP_GAIN);
        g_prod   = tps_pkg::RAMP_PROD_W'(pixel_y) * tps_pkg::RAMP_PROD_W'(tps_pkg::RAMP_GAIN);
        r_raw    = r_prod[tps_pkg::RAMP_PROD_W-1:8];
        g_raw    = g_prod[tps_pkg::RAMP_PROD_W-1:8];
        rg_sum   = {1'b0, r_raw} + {1'b0, g_raw};
        half_sum = rg_sum[tps_pkg::RAMP_W:1];
        // blue goes negative past a half sum of 15, clamp at zero
        if (half_sum > tps_pkg::RAMP_W'(tps_pkg::CHAN_MAX)) begin
            b_chan = '0;
        end else begin
            b_chan = tps_pkg::CHAN_W'(tps_pkg::CHAN_MAX) - half_sum[tps_pkg::CHAN_W-1:0];
        end
        addr_full = tps_pkg::ADDR_CALC_W'(pixel_y) * tps_pkg::ADDR_CALC_W'(tps_pkg::SCREEN_WIDTH)
                    + tps_pkg::ADDR_CALC_W'(pixel_x);

        item_next.fill  = cfg.fill_mode;
        item_next.dx_a  = delta(pixel_x, cfg.ax);
        item_next.dy_a  = delta(pixel_y, cfg.ay);
        item_next.dx_b  = delta(pixel_x, cfg.bx);
        item_next.dy_b  = delta(pixel_y, cfg.by);
        item_next.dx_c  = delta(pixel_x, cfg.cx);
        item_next.dy_c  = delta(pixel_y, cfg.cy);
        item_next.color = {tps_pkg::clamp_high(r_raw), tps_pkg::clamp_high(g_raw), b_chan};
        item_next.addr  = addr_full[tps_pkg::ADDR_W-1:0];
    end

    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (load) begin
            front_valid_next = 1'b1;
        end else if (push_ready) begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            front_valid_reg <= 1'b0;
        end else begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/tps_queue.sv
// small fifo between front and back stages
// depends on tps_pkg
`default_nettype none

module tps_queue #(
    parameter int DEPTH = tps_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push_valid,
    output logic                       push_ready,
    input  wire tps_pkg::queue_item_t  push_item,
    output logic                       pop_valid,
    input  wire logic                  pop_ready,
    output tps_pkg::queue_item_t       pop_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tps_pkg::queue_item_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_ready && pop_valid;
    assign pop_item   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### rtl/core/tps_back.sv
// back stages: edge products, then sign test and output register
// depends on tps_pkg
`default_nettype none

module tps_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tps_pkg::shader_cfg_t          cfg,
    input  wire logic                          pop_valid,
    output logic                               pop_ready,
    input  wire tps_pkg::queue_item_t          pop_item,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               inside_res,
    output logic [tps_pkg::COLOR_W-1:0]        pixel_color,
    output logic [tps_pkg::ADDR_W-1:0]         frame_address
);

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    tps_pkg::product_item_t s1_reg;
    tps_pkg::product_item_t s1_next;
    logic                   s1_load;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   inside_reg;
    logic                   inside_next;
    logic [tps_pkg::COLOR_W-1:0] color_reg;
    logic [tps_pkg::ADDR_W-1:0]  addr_reg;
    logic                   out_load;

    logic signed [tps_pkg::DELTA_W-1:0] ex0, ey0, ex1, ey1, ex2, ey2;
    logic signed [tps_pkg::EDGE_W-1:0]  e0, e1, e2;

    function automatic logic signed [tps_pkg::DELTA_W-1:0] span(
        input logic [tps_pkg::COORD_W-1:0] to_v,
        input logic [tps_pkg::COORD_W-1:0] from_v
    );
        return $signed({1'b0, to_v}) - $signed({1'b0, from_v});
    endfunction

    assign out_load  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign pop_ready = !s1_valid_reg || out_load;
    assign s1_load   = pop_valid && pop_ready;

    // edge directions a->b, b->c, c->a
    always_comb
    begin
        ex0 = span(cfg.bx, cfg.ax);
        ey0 = span(cfg.by, cfg.ay);
        ex1 = span(cfg.cx, cfg.bx);
        ey1 = span(cfg.cy, cfg.by);
        ex2 = span(cfg.ax, cfg.cx);
        ey2 = span(cfg.ay, cfg.cy);

        s1_next.fill  = pop_item.fill;
        s1_next.pa0   = pop_item.dx_a * ey0;
        s1_next.pb0   = pop_item.dy_a * ex0;
        s1_next.pa1   = pop_item.dx_b * ey1;
        s1_next.pb1   = pop_item.dy_b * ex1;
        s1_next.pa2   = pop_item.dx_c * ey2;
        s1_next.pb2   = pop_item.dy_c * ex2;
        s1_next.color = pop_item.color;
        s1_next.addr  = pop_item.addr;
    end

    always_comb
    begin
        e0 = tps_pkg::EDGE_W'(s1_reg.pa0) - tps_pkg::EDGE_W'(s1_reg.pb0);
        e1 = tps_pkg::EDGE_W'(s1_reg.pa1) - tps_pkg::EDGE_W'(s1_reg.pb1);
        e2 = tps_pkg::EDGE_W'(s1_reg.pa2) - tps_pkg::EDGE_W'(s1_reg.pb2);
        inside_next = s1_reg.fill
                      || (e0 >= 0 && e1 >= 0 && e2 >= 0)
                      || (e0 <= 0 && e1 <= 0 && e2 <= 0);
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_load) begin
            s1_valid_next = 1'b1;
        end else if (out_load) begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load) begin
            s1_reg <= s1_next;
        end
        if (out_load) begin
            inside_reg <= inside_next;
            color_reg  <= s1_reg.color;
            addr_reg   <= s1_reg.addr;
        end
    end

    assign out_valid     = out_valid_reg;
    assign inside_res    = inside_reg;
    assign pixel_color   = color_reg;
    assign frame_address = addr_reg;

endmodule

`default_nettype wire
